>>> rtl/ogic_pkg.sv
// Package for the online grid island counter.
// Holds field widths, register indexes, neighbour codes and the geometry struct.
// No dependencies.
`default_nettype none
package ogic_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int GEOM_W  = 7;
  localparam int COUNT_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Effective grid size, already limited to the maximum grid.
  typedef struct packed {
    logic [GEOM_W-1:0] rows;
    logic [GEOM_W-1:0] cols;
  } ogic_geom_t;

endpackage
`default_nettype wire

>>> rtl/ogic_if.sv
// Channel interfaces of the online grid island counter.
// Depends on ogic_pkg for the field widths.
`default_nettype none
interface ogic_in_if;
  import ogic_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;
  modport source (output valid, cell_row, cell_col, input ready);
  modport sink (input valid, cell_row, cell_col, output ready);
endinterface

interface ogic_out_if;
  import ogic_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] island_count;
  logic               bad_cell;
  modport source (output valid, island_count, bad_cell, input ready);
  modport sink (input valid, island_count, bad_cell, output ready);
endinterface

interface ogic_cfg_if;
  import ogic_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [GEOM_W-1:0]    data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

>>> rtl/online_grid_island_counter_unit.sv
// Online grid island counter: one result per cell taken, the island count after it.
// Result register loaded straight from idle for a cell outside the grid, and after
// a read of its entry for a cell already land; a new cell is marked land, then each
// direction is checked: off grid, water, or land (two finds with path compression and a
// union by size if the roots differ). One cell at a time; a full result register stalls.
// Reset (rst_n low, synchronous) starts a clearing pass over all MAX_ROWS*MAX_COLS cells.
`default_nettype none
module online_grid_island_counter_unit #(
  parameter int MAX_ROWS = ogic_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ogic_pkg::MAX_COLS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ogic_in_if.sink    in_ch,
  ogic_out_if.source out_ch,
  ogic_cfg_if.sink   cfg_ch
);
  import ogic_pkg::*;

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int IW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SW     = $clog2(NCELLS + 1);
  localparam int W      = IW + SW + 1;
  localparam int ROW_LIM = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int COL_LIM = (MAX_COLS < 127) ? MAX_COLS : 127;

  logic [GEOM_W-1:0] grid_rows_r;
  logic [GEOM_W-1:0] grid_cols_r;
  ogic_geom_t        geom;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [W-1:0]      ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [W-1:0]      ram_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GEOM_W'(64);
      grid_cols_r <= GEOM_W'(64);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_GRID_ROWS: grid_rows_r <= cfg_ch.data;
        REG_GRID_COLS: grid_cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign geom.rows = (grid_rows_r > GEOM_W'(ROW_LIM)) ? GEOM_W'(ROW_LIM) : grid_rows_r;
  assign geom.cols = (grid_cols_r > GEOM_W'(COL_LIM)) ? GEOM_W'(COL_LIM) : grid_cols_r;

  ogic_engine #(
    .NCELLS (NCELLS),
    .IW     (IW),
    .SW     (SW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ogic_ram #(
    .WIDTH (W),
    .DEPTH (NCELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

>>> rtl/ogic_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// A read of the address being written returns the new data. No dependencies.
`default_nettype none
module ogic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> rtl/ogic_engine.sv
// Sequencer of the island counter: clearing pass, land marking, neighbour
// finds with path compression, union by size and the result register.
// Depends on ogic_pkg, ogic_if and a RAM holding {land, parent, size} per cell.
`default_nettype none
module ogic_engine #(
  parameter int NCELLS = 4096,
  parameter int IW     = 12,
  parameter int SW     = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ogic_pkg::ogic_geom_t  geom,
  ogic_in_if.sink                    in_ch,
  ogic_out_if.source                 out_ch,
  output logic                       ram_we,
  output logic [IW-1:0]              ram_waddr,
  output logic [IW+SW:0]             ram_wdata,
  output logic [IW-1:0]              ram_raddr,
  input  wire logic [IW+SW:0]        ram_rdata
);
  import ogic_pkg::*;

  localparam int W    = IW + SW + 1;
  localparam int EW   = IW + 8;
  localparam int PAR_LO = SW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MRD, S_MCHK, S_NB, S_NCHK, S_FW, S_PC, S_FEND,
    S_UNION, S_UN2, S_DONE
  } state_t;

  state_t           state_r;
  logic [IW-1:0]    clr_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [IW-1:0]    me_r;
  logic [IW-1:0]    adj_r;
  logic [1:0]       k_r;
  logic [IW-1:0]    cur_r;
  logic [IW-1:0]    start_r;
  logic [IW-1:0]    node_r;
  logic [IW-1:0]    root_r;
  logic             phase_r;
  logic [IW-1:0]    ru_r;
  logic [IW-1:0]    rv_r;
  logic [W-1:0]     uw_r;
  logic [W-1:0]     vw_r;
  logic [IW-1:0]    win_r;
  logic [W-1:0]     winw_r;
  logic [SW-1:0]    islands_r;
  logic             bad_r;
  logic             out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic             out_bad_r;

  logic             rd_land;
  logic [IW-1:0]    rd_par;
  logic [SW-1:0]    rd_size;
  logic             nb_ok;
  logic [IW-1:0]    nb_adj;
  logic [EW-1:0]    me_e;
  logic [EW-1:0]    cols_e;
  logic [IW-1:0]    in_idx;
  logic             in_bad;
  logic             accept;
  logic             u_small;
  logic             load_out;

  assign rd_land = ram_rdata[W-1];
  assign rd_par  = ram_rdata[PAR_LO +: IW];
  assign rd_size = ram_rdata[SW-1:0];

  assign me_e   = EW'(me_r);
  assign cols_e = EW'(geom.cols);
  assign in_idx = IW'(EW'(in_ch.cell_row) * cols_e + EW'(in_ch.cell_col));
  assign in_bad = (GEOM_W'(in_ch.cell_row) >= geom.rows) ||
                  (GEOM_W'(in_ch.cell_col) >= geom.cols);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign u_small     = uw_r[SW-1:0] < vw_r[SW-1:0];
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.island_count = out_count_r;
  assign out_ch.bad_cell     = out_bad_r;

  always_comb begin
    nb_ok  = 1'b0;
    nb_adj = me_r;
    unique case (k_r)
      DIR_UP: begin
        nb_ok  = (row_r != '0);
        nb_adj = IW'(me_e - cols_e);
      end
      DIR_RIGHT: begin
        nb_ok  = (GEOM_W'(col_r) + GEOM_W'(1)) < geom.cols;
        nb_adj = IW'(me_e + EW'(1));
      end
      DIR_DOWN: begin
        nb_ok  = (GEOM_W'(row_r) + GEOM_W'(1)) < geom.rows;
        nb_adj = IW'(me_e + cols_e);
      end
      DIR_LEFT: begin
        nb_ok  = (col_r != '0);
        nb_adj = IW'(me_e - EW'(1));
      end
      default: ;
    endcase
  end

  // Memory port control; each state issues the read whose data the next state uses.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = me_r;
    ram_wdata = ram_rdata;
    ram_raddr = me_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b0, clr_r, SW'(1)};
      end
      S_MCHK: begin
        ram_we    = !rd_land;
        ram_wdata = {1'b1, ram_rdata[W-2:0]};
      end
      S_NB:   ram_raddr = nb_adj;
      S_FW:   ram_raddr = (rd_par == cur_r) ? start_r : rd_par;
      S_PC: begin
        ram_we    = 1'b1;
        ram_waddr = node_r;
        ram_wdata = {rd_land, root_r, rd_size};
        ram_raddr = rd_par;
      end
      S_FEND: ram_raddr = adj_r;
      S_UNION: begin
        ram_we = (ru_r != rv_r);
        if (u_small) begin
          ram_waddr = ru_r;
          ram_wdata = {uw_r[W-1], rv_r, uw_r[SW-1:0]};
        end else begin
          ram_waddr = rv_r;
          ram_wdata = {vw_r[W-1], ru_r, vw_r[SW-1:0]};
        end
      end
      S_UN2: begin
        ram_we    = 1'b1;
        ram_waddr = win_r;
        ram_wdata = winw_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      islands_r   <= '0;
      out_valid_r <= 1'b0;
      k_r         <= DIR_UP;
      phase_r     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(NCELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            row_r   <= in_ch.cell_row;
            col_r   <= in_ch.cell_col;
            me_r    <= in_idx;
            bad_r   <= in_bad;
            state_r <= in_bad ? S_DONE : S_MRD;
          end
        end
        S_MRD: state_r <= S_MCHK;
        S_MCHK: begin
          if (rd_land) begin
            state_r <= S_DONE;
          end else begin
            islands_r <= islands_r + SW'(1);
            k_r       <= DIR_UP;
            state_r   <= S_NB;
          end
        end
        S_NB: begin
          if (nb_ok) begin
            adj_r   <= nb_adj;
            state_r <= S_NCHK;
          end else if (k_r == DIR_LEFT) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_NCHK: begin
          if (rd_land) begin
            cur_r   <= me_r;
            start_r <= me_r;
            phase_r <= 1'b0;
            state_r <= S_FW;
          end else if (k_r == DIR_LEFT) begin
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_NB;
          end
        end
        S_FW: begin
          if (rd_par == cur_r) begin
            root_r <= cur_r;
            node_r <= start_r;
            if (phase_r) begin
              rv_r <= cur_r;
              vw_r <= ram_rdata;
            end else begin
              ru_r <= cur_r;
              uw_r <= ram_rdata;
            end
            state_r <= (start_r == cur_r) ? S_FEND : S_PC;
          end else begin
            cur_r <= rd_par;
          end
        end
        S_PC: begin
          if (rd_par == root_r) begin
            state_r <= S_FEND;
          end else begin
            node_r <= rd_par;
          end
        end
        S_FEND: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            cur_r   <= adj_r;
            start_r <= adj_r;
            state_r <= S_FW;
          end else begin
            state_r <= S_UNION;
          end
        end
        S_UNION: begin
          if (ru_r == rv_r) begin
            if (k_r == DIR_LEFT) begin
              state_r <= S_DONE;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_NB;
            end
          end else begin
            if (u_small) begin
              win_r  <= rv_r;
              winw_r <= {vw_r[W-1:SW], vw_r[SW-1:0] + uw_r[SW-1:0]};
            end else begin
              win_r  <= ru_r;
              winw_r <= {uw_r[W-1:SW], uw_r[SW-1:0] + vw_r[SW-1:0]};
            end
            if (islands_r != '0) begin
              islands_r <= islands_r - SW'(1);
            end
            state_r <= S_UN2;
          end
        end
        S_UN2: begin
          if (k_r == DIR_LEFT) begin
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_NB;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_count_r <= COUNT_W'(islands_r);
            out_bad_r   <= bad_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("engine still idle after taking a cell");

  a_island_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (islands_r == $past(islands_r) ||
                      islands_r == $past(islands_r) + SW'(1) ||
                      islands_r == $past(islands_r) - SW'(1)))
    else $error("island count moved by more than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before it was taken");

  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && bad_r) |-> !ram_we)
    else $error("memory written for a cell outside the grid");

endmodule
`default_nettype wire
